>>> sv/mcoc_pkg.sv
// shared constants and state type for the matrix chain cost unit
`timescale 1ns / 1ps
`default_nettype none

package mcoc_pkg;

    localparam int COST_BITS = 42;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_CELL_DI,
        ST_CELL_DJ,
        ST_LOOP,
        ST_DRAIN,
        ST_WRITE,
        ST_FINISH
    } mcoc_state_t;

endpackage

`default_nettype wire

>>> sv/matrix_chain_order_cost_unit.sv
// matrix chain order cost: dimension loader, cost table sequencer and result register
`timescale 1ns / 1ps
`default_nettype none

// channel | direction | ports                          | meaning
// s_      | in        | s_valid s_ready s_dimension s_last | one chain dimension, d0 first
// m_      | out       | m_valid m_ready m_min_cost m_overflow | least cost of the chain
//
// loading takes one cycle per dimension word; s_ready stays high while words load
// after the word flagged last, a chain of n dimensions (n >= 3) is worked through
//   cell by cell by the single split loop over the cost table memory
//   (one split per cycle within a cell; each cell then drains the split pipeline)
// shorter chains go straight to the result; the result then waits for a free output register
// reset (aresetn low, synchronous) clears the count, flags, state and output valid;
// the memories are not cleared, every entry whose value is used is written before it is read
// s_ready is low from the last word until the result is in the output register

module matrix_chain_order_cost_unit #(
    parameter int MAX_DIMS = 64,
    parameter int DIM_BITS = 12
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [DIM_BITS-1:0]           s_dimension,
    input  wire logic                          s_last,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [mcoc_pkg::COST_BITS-1:0]     m_min_cost,
    output logic                               m_overflow
);

    import mcoc_pkg::*;

    localparam int AW      = $clog2(MAX_DIMS);
    localparam int CW      = AW + 1;
    localparam int CT_SIZE = 1 << (2 * AW);
    localparam int P1W     = 2 * DIM_BITS;
    localparam int PW      = 3 * DIM_BITS;
    localparam int XW      = (PW > COST_BITS) ? PW : COST_BITS;

    // state
    mcoc_state_t state_reg, state_next;

    // dimension memory and cost table memory
    logic [DIM_BITS-1:0]  dims_mem [MAX_DIMS];
    logic [COST_BITS-1:0] cost_mem [CT_SIZE];

    logic [DIM_BITS-1:0]  dims_rd_reg;
    logic [COST_BITS-1:0] cost_l_rd_reg;
    logic [COST_BITS-1:0] cost_r_rd_reg;

    // chain bookkeeping
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] n_reg, n_next;
    logic          ovf_reg, ovf_next;

    // table sequencer
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] i_reg, i_next;
    logic [AW-1:0] k_reg, k_next;
    logic [AW-1:0] j_idx;
    logic [AW-1:0] k_plus;

    logic [DIM_BITS-1:0]  di1_reg, di1_next;
    logic [DIM_BITS-1:0]  dj_reg, dj_next;
    logic [COST_BITS-1:0] best_reg, best_next;

    // split pipeline: read, first product and pair sum, full product
    logic           p1_valid_reg, p1_lz_reg, p1_rz_reg;
    logic           p2_valid_reg;
    logic [COST_BITS-1:0] p2_lr_reg;
    logic [P1W-1:0] p2_prod_reg;
    logic           p3_valid_reg;
    logic [COST_BITS-1:0] p3_lr_reg;
    logic [COST_BITS-1:0] p3_prod_reg;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [COST_BITS-1:0] m_min_cost_reg, m_min_cost_next;
    logic                 m_overflow_reg, m_overflow_next;

    // control decodes
    logic          s_fire;
    logic          full;
    logic [CW-1:0] n_load;
    logic          out_free;
    logic          last_cell;
    logic          last_len;
    logic          loop_end;
    logic          pipe_empty;
    logic          dims_we;
    logic          issue;
    logic [AW-1:0] dims_raddr;

    // stage arithmetic
    logic [COST_BITS-1:0] left_c, right_c;
    logic [COST_BITS:0]   lr_sum;
    logic [COST_BITS-1:0] lr_sat;
    logic [PW-1:0]        prod_full;
    logic [XW-1:0]        prod_x;
    logic [COST_BITS-1:0] prod_sat;
    logic [COST_BITS:0]   t_sum;
    logic [COST_BITS-1:0] t_sat;

    assign j_idx      = i_reg + len_reg - AW'(1);
    assign k_plus     = k_reg + AW'(1);
    assign s_fire     = s_valid && s_ready;
    assign full       = (count_reg == CW'(MAX_DIMS));
    assign n_load     = full ? count_reg : count_reg + CW'(1);
    assign out_free   = !m_valid_reg || m_ready;
    assign last_cell  = (({1'b0, i_reg} + {1'b0, len_reg}) == n_reg);
    assign last_len   = (({1'b0, len_reg} + CW'(1)) == n_reg);
    assign loop_end   = (k_plus == j_idx);
    assign pipe_empty = !p1_valid_reg && !p2_valid_reg && !p3_valid_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire && s_last) begin
                    state_next = (n_load < CW'(3)) ? ST_FINISH : ST_CELL_DI;
                end
            end
            ST_CELL_DI: state_next = ST_CELL_DJ;
            ST_CELL_DJ: state_next = ST_LOOP;
            ST_LOOP: begin
                if (loop_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (pipe_empty) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (last_cell && last_len) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_CELL_DI;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_LOAD;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready    = 1'b0;
        dims_we    = 1'b0;
        issue      = 1'b0;
        dims_raddr = k_reg;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                dims_we = s_fire && !full;
            end
            ST_CELL_DI: dims_raddr = i_reg - AW'(1);
            ST_CELL_DJ: dims_raddr = j_idx;
            ST_LOOP:    issue      = 1'b1;
            ST_DRAIN, ST_WRITE, ST_FINISH: begin
            end
            default: begin
            end
        endcase
    end

    // split arithmetic
    always_comb begin
        left_c    = p1_lz_reg ? '0 : cost_l_rd_reg;
        right_c   = p1_rz_reg ? '0 : cost_r_rd_reg;
        lr_sum    = {1'b0, left_c} + {1'b0, right_c};
        lr_sat    = lr_sum[COST_BITS] ? COST_MAX : lr_sum[COST_BITS-1:0];
        prod_full = PW'(p2_prod_reg) * PW'(dj_reg);
        prod_x    = XW'(prod_full);
        prod_sat  = (prod_x > XW'(COST_MAX)) ? COST_MAX : prod_x[COST_BITS-1:0];
        t_sum     = {1'b0, p3_lr_reg} + {1'b0, p3_prod_reg};
        t_sat     = t_sum[COST_BITS] ? COST_MAX : t_sum[COST_BITS-1:0];
    end

    // register next values
    always_comb begin
        count_next      = count_reg;
        n_next          = n_reg;
        ovf_next        = ovf_reg;
        len_next        = len_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        di1_next        = di1_reg;
        dj_next         = dj_reg;
        best_next       = best_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_min_cost_next = m_min_cost_reg;
        m_overflow_next = m_overflow_reg;

        // a split result that beats the running minimum replaces it
        if (p3_valid_reg && (t_sat < best_reg)) begin
            best_next = t_sat;
        end

        unique case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (full) begin
                        ovf_next = 1'b1;
                    end else begin
                        count_next = count_reg + CW'(1);
                    end
                    if (s_last) begin
                        n_next    = n_load;
                        len_next  = AW'(2);
                        i_next    = AW'(1);
                        best_next = '0;
                    end
                end
            end
            ST_CELL_DI: begin
                best_next = COST_MAX;
            end
            ST_CELL_DJ: begin
                di1_next = dims_rd_reg;
                k_next   = i_reg;
            end
            ST_LOOP: begin
                // first split cycle sees d[j] from the read issued in ST_CELL_DJ
                if (k_reg == i_reg) begin
                    dj_next = dims_rd_reg;
                end
                k_next = k_plus;
            end
            ST_DRAIN: begin
            end
            ST_WRITE: begin
                if (last_cell) begin
                    len_next = len_reg + AW'(1);
                    i_next   = AW'(1);
                end else begin
                    i_next = i_reg + AW'(1);
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_min_cost_next = best_reg;
                    m_overflow_next = ovf_reg;
                    count_next      = '0;
                    ovf_next        = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // dimension memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (dims_we) begin
            dims_mem[count_reg[AW-1:0]] <= s_dimension;
        end
        dims_rd_reg <= dims_mem[dims_raddr];
    end

    // cost table: cost(i,k) and cost(k+1,j) read together, cost(i,j) written at cell end
    always_ff @(posedge aclk) begin
        if (state_reg == ST_WRITE) begin
            cost_mem[{i_reg, j_idx}] <= best_reg;
        end
        cost_l_rd_reg <= cost_mem[{i_reg, k_reg}];
        cost_r_rd_reg <= cost_mem[{k_plus, j_idx}];
    end

    // split pipeline payload
    always_ff @(posedge aclk) begin
        p1_lz_reg   <= (k_reg == i_reg);
        p1_rz_reg   <= loop_end;
        p2_lr_reg   <= lr_sat;
        p2_prod_reg <= P1W'(di1_reg) * P1W'(dims_rd_reg);
        p3_lr_reg   <= p2_lr_reg;
        p3_prod_reg <= prod_sat;
    end

    // payload registers
    always_ff @(posedge aclk) begin
        n_reg          <= n_next;
        len_reg        <= len_next;
        i_reg          <= i_next;
        k_reg          <= k_next;
        di1_reg        <= di1_next;
        dj_reg         <= dj_next;
        best_reg       <= best_next;
        m_min_cost_reg <= m_min_cost_next;
        m_overflow_reg <= m_overflow_next;
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_min_cost = m_min_cost_reg;
    assign m_overflow = m_overflow_reg;

endmodule

`default_nettype wire

>>> sv/mcoc_checker.sv
// port-level checks for the matrix chain cost unit, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module mcoc_checker #(
    parameter int DIM_BITS = 12
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [DIM_BITS-1:0]           s_dimension,
    input wire logic                          s_last,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [mcoc_pkg::COST_BITS-1:0] m_min_cost,
    input wire logic                          m_overflow
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_min_cost) && $stable(m_overflow))
        else $error("result word changed while stalled");

    // the block stops taking words after the last word of a chain
    a_busy_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last |=> !s_ready)
        else $error("input ready right after a last word");

    // a new result appears only out of the busy phase
    a_result_from_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result appeared while loading");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

    // a dimension word is always paired with a defined flag
    a_last_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !$isunknown(s_last) && !$isunknown(s_dimension))
        else $error("unknown input word accepted");

endmodule

bind matrix_chain_order_cost_unit mcoc_checker #(
    .DIM_BITS(DIM_BITS)
) u_mcoc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_dimension (s_dimension),
    .s_last      (s_last),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_min_cost  (m_min_cost),
    .m_overflow  (m_overflow)
);

`default_nettype wire
